// ===== sv/tbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

  // CORDIC iteration count and the width of the step index into the angle table
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int IDX_W            = 5;

  // datapath widths
  localparam int CW     = 34;  // CORDIC x and y
  localparam int ZW     = 27;  // CORDIC angle accumulator
  localparam int DIV_W  = 36;  // divider dividend and quotient
  localparam int WW     = 40;  // headroom for dividend forming
  localparam int ANG_W  = 25;  // Q16.16 angle
  localparam int APW    = 26;  // angle plus gyro step
  localparam int RW     = 28;  // gyro rate
  localparam int EW     = 21;  // clamped error
  localparam int DW     = 29;  // derivative term
  localparam int IW     = 30;  // error integral
  localparam int AW     = 64;  // PID accumulator

  // fixed-point limits
  localparam int DEG180     = 11796480;
  localparam int DEADBAND_Q = 9830;
  localparam int ERR_MAX_Q  = 786432;
  localparam int INT_MAX_Q  = 335544320;
  localparam logic signed [AW-1:0] DRIVE_MAX = 64'sd999 <<< 32;
  localparam logic signed [AW-1:0] KICK      = 64'sd260 <<< 32;

  // register reset values
  localparam logic [15:0] PROP_GAIN_RST  = 16'd4608;
  localparam logic [15:0] INTEG_GAIN_RST = 16'd154;
  localparam logic [15:0] DERIV_GAIN_RST = 16'd307;

  typedef enum logic [2:0] {
    R_PROP, R_INTEG, R_DERIV, R_TARGET, R_AXB, R_AZB, R_GYB
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] prop_gain;
    logic        [15:0] integ_gain;
    logic        [15:0] deriv_gain;
    logic signed [24:0] target_angle;
    logic signed [15:0] accel_x_bias;
    logic signed [15:0] accel_z_bias;
    logic signed [25:0] gyro_bias;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_ROT, S_FIX, S_DIV_GO, S_DIV_WAIT, S_ERR, S_MUL, S_SAT, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PRE, OP_ROT, OP_FIX, OP_DIV_START, OP_DIV_TAKE,
    OP_ERR, OP_MUL, OP_SAT, OP_FIN
  } op_t;

  typedef enum logic [2:0] {
    DS_RATE, DS_STEP, DS_FILT, DS_DECAY, DS_ADD
  } div_sel_t;

  typedef enum logic [1:0] {
    MS_P, MS_I, MS_D
  } mul_sel_t;

  typedef struct packed {
    op_t              op;
    div_sel_t         div_sel;
    mul_sel_t         mul_sel;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic deadband;
    logic out_full;
  } status_t;

  // atan(2^-i) in degrees, Q16.16
  function automatic logic [21:0] atan_lut(input logic [IDX_W-1:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tbp_div25.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Floor division by 25 as radix-4096 long division: each quotient digit comes
// from a reciprocal multiply of the partial remainder, one digit per cycle
module tbp_div25 import tbp_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [DIV_W-1:0] dividend,
  output logic                         done,
  output logic signed [DIV_W-1:0]      quot
);

  localparam int DIG_W  = 12;
  localparam int NDIG   = DIV_W / DIG_W;
  localparam int CNT_W  = $clog2(NDIG);
  localparam int RCP_SH = 22;
  // ceil(2^22 / 25); exact for partial remainders below 25 * 4096
  localparam logic [17:0] RCP = 18'd167773;

  logic                 busy_r;
  logic                 done_r;
  logic                 neg_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_W-1:0]     dvd_r;
  logic [DIV_W-1:0]     q_r;
  logic [4:0]           rem_r;

  logic signed [DIV_W:0] ext_w;
  logic [DIV_W:0]        mag_w;
  logic [16:0]           trial_w;
  logic [34:0]           prod_w;
  logic [DIG_W-1:0]      qd_w;
  logic [16:0]           back_w;

  // negative dividends: floor(m/25) = -floor((|m|+24)/25)
  always_comb begin
    ext_w   = (DIV_W+1)'(dividend);
    mag_w   = dividend[DIV_W-1] ? (DIV_W+1)'(24 - ext_w) : (DIV_W+1)'(ext_w);
    trial_w = {rem_r, dvd_r[DIV_W-1 -: DIG_W]};
    prod_w  = 35'(trial_w) * 35'(RCP);
    qd_w    = prod_w[RCP_SH+DIG_W-1:RCP_SH];
    back_w  = trial_w - 17'(qd_w) * 17'd25;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= dividend[DIV_W-1];
        dvd_r  <= mag_w[DIV_W-1:0];
        q_r    <= '0;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= back_w[4:0];
        dvd_r <= {dvd_r[DIV_W-DIG_W-1:0], {DIG_W{1'b0}}};
        q_r   <= {q_r[DIV_W-DIG_W-1:0], qd_w};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NDIG-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

`default_nettype wire

// ===== sv/tbp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: CORDIC iterations, division passes, PID multiplies
module tbp_ctrl import tbp_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  div_sel_t         dsel_r, dsel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      dsel_r  <= DS_RATE;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dsel_r  <= dsel_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dsel_nxt  = dsel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PRE;
          cnt_nxt   = '0;
        end
      end
      S_PRE: state_nxt = S_ROT;
      S_ROT: begin
        if (cnt_r == IDX_W'(CORDIC_STEPS-1)) begin
          state_nxt = S_FIX;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIX: begin
        state_nxt = S_DIV_GO;
        dsel_nxt  = DS_RATE;
      end
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (status.div_done) begin
          unique case (dsel_r)
            DS_RATE: begin
              dsel_nxt  = DS_STEP;
              state_nxt = S_DIV_GO;
            end
            DS_STEP: begin
              dsel_nxt  = DS_FILT;
              state_nxt = S_DIV_GO;
            end
            DS_FILT: state_nxt = S_ERR;
            DS_DECAY: begin
              dsel_nxt  = DS_ADD;
              state_nxt = S_DIV_GO;
            end
            default: begin
              state_nxt = S_MUL;
              cnt_nxt   = '0;
            end
          endcase
        end
      end
      S_ERR: begin
        dsel_nxt  = status.deadband ? DS_DECAY : DS_ADD;
        state_nxt = S_DIV_GO;
      end
      S_MUL: begin
        if (cnt_r == IDX_W'(MS_D)) begin
          state_nxt = S_SAT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SAT: state_nxt = S_FIN;
      S_FIN: begin
        if (!status.out_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd.op      = OP_NONE;
    cmd.div_sel = dsel_r;
    cmd.mul_sel = mul_sel_t'(cnt_r[1:0]);
    cmd.idx     = cnt_r;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
        end
      end
      S_PRE:      cmd.op = OP_PRE;
      S_ROT:      cmd.op = OP_ROT;
      S_FIX:      cmd.op = OP_FIX;
      S_DIV_GO:   cmd.op = OP_DIV_START;
      S_DIV_WAIT: cmd.op = status.div_done ? OP_DIV_TAKE : OP_NONE;
      S_ERR:      cmd.op = OP_ERR;
      S_MUL:      cmd.op = OP_MUL;
      S_SAT:      cmd.op = OP_SAT;
      S_FIN:      cmd.op = status.out_full ? OP_NONE : OP_FIN;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/tbp_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Datapath: CORDIC atan2, filter, PID state and drive computation
module tbp_dpath import tbp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  input  wire cfg_t               cfg,
  input  wire logic signed [15:0] accel_x_sample,
  input  wire logic signed [15:0] accel_z_sample,
  input  wire logic signed [15:0] gyro_x_sample,
  output logic                    div_done,
  output logic                    deadband,
  output logic [9:0]              pwm_duty,
  output logic                    motor_direction,
  output logic signed [ANG_W-1:0] filtered_angle
);

  localparam logic signed [CW-1:0] XSCALE = CW'(159744);
  localparam logic signed [CW-1:0] BSCALE = CW'(10000);

  // CORDIC registers
  logic signed [CW-1:0]    x_r, y_r;
  logic signed [ZW-1:0]    z_r;
  logic                    spec_r;
  logic signed [15:0]      g_r;
  logic signed [ANG_W-1:0] acc_r;

  // controller state
  logic signed [ANG_W-1:0] fused_r;
  logic                    first_r;
  logic signed [IW-1:0]    integ_r;
  logic signed [EW-1:0]    prev_r;

  // per-item working registers
  logic signed [RW-1:0]    rate_r;
  logic signed [APW-1:0]   ang_pre_r;
  logic signed [EW-1:0]    err_r;
  logic signed [DW-1:0]    d_r;
  logic signed [IW-1:0]    ibase_r;
  logic signed [AW-1:0]    pid_r;
  logic signed [AW-1:0]    u_r;

  logic signed [CW-1:0]    ax_w, az_w, xs_w, ys_w;
  logic signed [ZW-1:0]    at_w;
  logic signed [WW-1:0]    dv_w;
  logic signed [DIV_W-1:0] dividend_w, quot_w, qsum_w;
  logic                    div_start_w;
  logic signed [APW-1:0]   e_w;
  logic signed [EW-1:0]    ec_w;
  logic signed [31:0]      mop_w;
  logic [15:0]             gain_w;
  logic signed [48:0]      prod_w;
  logic signed [AW-1:0]    t_w, un_w, mag_w;

  // accel scaling and CORDIC step terms
  always_comb begin
    ax_w = CW'($signed(accel_x_sample[15:6])) * XSCALE - CW'(cfg.accel_x_bias) * BSCALE;
    az_w = CW'($signed(accel_z_sample[15:6])) * XSCALE - CW'(cfg.accel_z_bias) * BSCALE;
    xs_w = x_r >>> cmd.idx;
    ys_w = y_r >>> cmd.idx;
    at_w = ZW'({1'b0, atan_lut(cmd.idx)});
  end

  // dividend select; every division here reduces to floor(m/25)
  always_comb begin
    unique case (cmd.div_sel)
      DS_RATE:  dv_w = (WW'(g_r) * WW'(57344) + WW'(50)) >>> 2;
      DS_STEP:  dv_w = (WW'(rate_r) + WW'(50)) >>> 2;
      DS_FILT:  dv_w = (WW'(ang_pre_r) * WW'(98) + WW'(acc_r) * WW'(2) + WW'(50)) >>> 2;
      DS_DECAY: dv_w = (WW'(integ_r) * WW'(199) + WW'(100)) >>> 3;
      default:  dv_w = (WW'(err_r) * WW'(256) + WW'(50)) >>> 2;
    endcase
    dividend_w  = dv_w[DIV_W-1:0];
    div_start_w = (cmd.op == OP_DIV_START);
  end

  tbp_div25 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_w),
    .dividend (dividend_w),
    .done     (div_done),
    .quot     (quot_w)
  );

  // error, deadband and clamp
  always_comb begin
    e_w      = APW'(cfg.target_angle) - APW'(fused_r);
    deadband = (e_w >= -APW'(DEADBAND_Q)) && (e_w <= APW'(DEADBAND_Q));
    if (deadband) begin
      ec_w = '0;
    end else if (e_w > APW'(ERR_MAX_Q)) begin
      ec_w = EW'(ERR_MAX_Q);
    end else if (e_w < -APW'(ERR_MAX_Q)) begin
      ec_w = -EW'(ERR_MAX_Q);
    end else begin
      ec_w = EW'(e_w);
    end
    qsum_w = DIV_W'(ibase_r) + quot_w;
  end

  // shared multiplier for the three PID terms
  always_comb begin
    unique case (cmd.mul_sel)
      MS_P: begin
        gain_w = cfg.prop_gain;
        mop_w  = 32'(err_r);
      end
      MS_I: begin
        gain_w = cfg.integ_gain;
        mop_w  = 32'(integ_r);
      end
      default: begin
        gain_w = cfg.deriv_gain;
        mop_w  = 32'(d_r);
      end
    endcase
    prod_w = 49'($signed({1'b0, gain_w})) * 49'(mop_w);
  end

  // drive scaling by -30 for saturation, minimum kick, duty and direction
  always_comb begin
    t_w  = (pid_r <<< 5) - (pid_r <<< 1);
    un_w = -t_w;
    mag_w = u_r[AW-1] ? -u_r : u_r;
    if (mag_w != '0 && mag_w < KICK) begin
      mag_w = KICK;
    end
    pwm_duty        = mag_w[41:32];
    motor_direction = ~u_r[AW-1];
    filtered_angle  = fused_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fused_r <= '0;
      first_r <= 1'b1;
      integ_r <= '0;
      prev_r  <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          x_r <= az_w;
          y_r <= ax_w;
          g_r <= gyro_x_sample;
        end
        OP_PRE: begin
          // zero y and the left half plane are folded in here
          if (y_r == '0) begin
            spec_r <= 1'b1;
            z_r    <= x_r[CW-1] ? ZW'(DEG180) : '0;
          end else if (x_r[CW-1]) begin
            spec_r <= 1'b0;
            z_r    <= y_r[CW-1] ? -ZW'(DEG180) : ZW'(DEG180);
            x_r    <= -x_r;
            y_r    <= -y_r;
          end else begin
            spec_r <= 1'b0;
            z_r    <= '0;
          end
        end
        OP_ROT: begin
          if (!spec_r) begin
            if (!y_r[CW-1]) begin
              x_r <= x_r + ys_w;
              y_r <= y_r - xs_w;
              z_r <= z_r + at_w;
            end else begin
              x_r <= x_r - ys_w;
              y_r <= y_r + xs_w;
              z_r <= z_r - at_w;
            end
          end
        end
        OP_FIX: begin
          if (z_r > ZW'(DEG180)) begin
            acc_r <= ANG_W'(DEG180);
          end else if (z_r < -ZW'(DEG180)) begin
            acc_r <= -ANG_W'(DEG180);
          end else begin
            acc_r <= ANG_W'(z_r);
          end
          if (first_r) begin
            first_r <= 1'b0;
            if (z_r > ZW'(DEG180)) begin
              fused_r <= ANG_W'(DEG180);
            end else if (z_r < -ZW'(DEG180)) begin
              fused_r <= -ANG_W'(DEG180);
            end else begin
              fused_r <= ANG_W'(z_r);
            end
          end
        end
        OP_DIV_TAKE: begin
          unique case (cmd.div_sel)
            DS_RATE:  rate_r    <= RW'(quot_w - DIV_W'(cfg.gyro_bias));
            DS_STEP:  ang_pre_r <= APW'(quot_w) + APW'(fused_r);
            DS_FILT: begin
              if (quot_w > DIV_W'(DEG180)) begin
                fused_r <= ANG_W'(DEG180);
              end else if (quot_w < -DIV_W'(DEG180)) begin
                fused_r <= -ANG_W'(DEG180);
              end else begin
                fused_r <= ANG_W'(quot_w);
              end
            end
            DS_DECAY: ibase_r <= IW'(quot_w);
            default: begin
              if (qsum_w > DIV_W'(INT_MAX_Q)) begin
                integ_r <= IW'(INT_MAX_Q);
              end else if (qsum_w < -DIV_W'(INT_MAX_Q)) begin
                integ_r <= -IW'(INT_MAX_Q);
              end else begin
                integ_r <= IW'(qsum_w);
              end
            end
          endcase
        end
        OP_ERR: begin
          err_r   <= ec_w;
          d_r     <= (DW'(ec_w) - DW'(prev_r)) * DW'(100);
          prev_r  <= ec_w;
          ibase_r <= integ_r;
          pid_r   <= '0;
        end
        OP_MUL: begin
          pid_r <= pid_r + ((cmd.mul_sel == MS_I) ? AW'(prod_w) : (AW'(prod_w) <<< 8));
        end
        OP_SAT: begin
          if (un_w > DRIVE_MAX) begin
            u_r <= DRIVE_MAX;
          end else if (un_w < -DRIVE_MAX) begin
            u_r <= -DRIVE_MAX;
          end else begin
            u_r <= un_w;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/tilt_balance_pid_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tilt balance controller: complementary filter and PID per control tick.
// Input channel (in_valid/in_ready) takes one request of raw accel X, accel
// Z and gyro X words; the result channel (out_valid/out_ready) returns PWM
// duty, motor direction and the fused angle in Q16.16 degrees, one result
// per request. Registers are written over the APB port (psel/penable/...,
// byte address 4*index), pready is tied high, and reads return the value.
// Each request runs through the CORDIC iterations and then through four
// divide-by-25 passes, or five when the error falls inside the deadband;
// one request is worked on at a time, and a new one is taken the cycle
// after the previous result is loaded.
// A result waits in the output register while the receiver stalls; the
// next request is still accepted and runs until its result would overwrite.
// Reset (synchronous, active low) restores register defaults, clears the
// filter and PID state and arms the first-sample seeding of the filter.
module tilt_balance_pid_controller import tbp_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_accel_x_sample,
  input  wire logic signed [15:0] in_accel_z_sample,
  input  wire logic signed [15:0] in_gyro_x_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [9:0]              out_pwm_duty,
  output logic                    out_motor_direction,
  output logic signed [24:0]      out_filtered_angle,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t status;

  logic                    out_valid_r;
  logic [9:0]              duty_r;
  logic                    dir_r;
  logic signed [ANG_W-1:0] ang_r;

  logic [9:0]              dp_duty;
  logic                    dp_dir;
  logic signed [ANG_W-1:0] dp_ang;
  logic                    dp_div_done;
  logic                    dp_deadband;
  logic                    wr_en;

  // register writes
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain    <= PROP_GAIN_RST;
      cfg_r.integ_gain   <= INTEG_GAIN_RST;
      cfg_r.deriv_gain   <= DERIV_GAIN_RST;
      cfg_r.target_angle <= '0;
      cfg_r.accel_x_bias <= '0;
      cfg_r.accel_z_bias <= '0;
      cfg_r.gyro_bias    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(paddr[4:2]))
        R_PROP:   cfg_r.prop_gain    <= pwdata[15:0];
        R_INTEG:  cfg_r.integ_gain   <= pwdata[15:0];
        R_DERIV:  cfg_r.deriv_gain   <= pwdata[15:0];
        R_TARGET: cfg_r.target_angle <= pwdata[24:0];
        R_AXB:    cfg_r.accel_x_bias <= pwdata[15:0];
        R_AZB:    cfg_r.accel_z_bias <= pwdata[15:0];
        R_GYB:    cfg_r.gyro_bias    <= pwdata[25:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      R_PROP:   prdata = 32'(cfg_r.prop_gain);
      R_INTEG:  prdata = 32'(cfg_r.integ_gain);
      R_DERIV:  prdata = 32'(cfg_r.deriv_gain);
      R_TARGET: prdata = 32'(cfg_r.target_angle);
      R_AXB:    prdata = 32'(cfg_r.accel_x_bias);
      R_AZB:    prdata = 32'(cfg_r.accel_z_bias);
      R_GYB:    prdata = 32'(cfg_r.gyro_bias);
      default:  prdata = '0;
    endcase
  end

  assign status.div_done = dp_div_done;
  assign status.deadband = dp_deadband;
  assign status.out_full = out_valid_r & ~out_ready;

  tbp_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tbp_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg_r),
    .accel_x_sample  (in_accel_x_sample),
    .accel_z_sample  (in_accel_z_sample),
    .gyro_x_sample   (in_gyro_x_sample),
    .div_done        (dp_div_done),
    .deadband        (dp_deadband),
    .pwm_duty        (dp_duty),
    .motor_direction (dp_dir),
    .filtered_angle  (dp_ang)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_FIN) begin
        out_valid_r <= 1'b1;
        duty_r      <= dp_duty;
        dir_r       <= dp_dir;
        ang_r       <= dp_ang;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pwm_duty        = duty_r;
  assign out_motor_direction = dir_r;
  assign out_filtered_angle  = ang_r;

endmodule

`default_nettype wire

// ===== tb/tb_tilt_checker.sv =====
`timescale 1ns / 1ps

module tb_tilt_checker import tbp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_accel_x_sample,
  input  logic signed [15:0] in_accel_z_sample,
  input  logic signed [15:0] in_gyro_x_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [9:0]         out_pwm_duty,
  input  logic               out_motor_direction,
  input  logic signed [24:0] out_filtered_angle,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [9:0]         duty;
    logic               dir;
    logic signed [24:0] angle;
  } drive_t;

  localparam longint A180 = 64'sd11796480;
  localparam longint DRV_MAX = 64'sd999 <<< 32;
  localparam longint KICK_MIN = 64'sd260 <<< 32;

  // mirrored registers and controller state
  cfg_t   regs;
  longint m_angle, m_integ, m_prev;
  bit     m_seed;
  drive_t drive_q[$];

  function automatic longint fl_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint lim(longint v, longint l);
    return v > l ? l : (v < -l ? -l : v);
  endfunction

  // vectoring CORDIC, degrees Q16.16
  function automatic longint tilt_atan2(longint y, longint x);
    longint z, xs, ys;
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
                        14, 7, 4, 2, 1, 0};
    z = 0;
    if (y == 0) return x < 0 ? A180 : 0;
    if (x < 0) begin
      z = y > 0 ? A180 : -A180;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += tbl[i];
      end else begin
        x -= ys; y += xs; z -= tbl[i];
      end
    end
    return lim(z, A180);
  endfunction

  function automatic drive_t predict_drive(logic signed [15:0] sx, logic signed [15:0] sz,
                                           logic signed [15:0] sg);
    longint ax, az, acc, rate, ang, err, integ, deriv, u, mag;
    drive_t r;
    ax = longint'(sx >>> 6) * 159744 - longint'(regs.accel_x_bias) * 10000;
    az = longint'(sz >>> 6) * 159744 - longint'(regs.accel_z_bias) * 10000;
    acc = tilt_atan2(ax, az);
    rate = fl_div(longint'(sg) * 458752 + 400, 800) - longint'(regs.gyro_bias);
    if (m_seed) begin
      m_angle = acc;
      m_seed = 0;
    end
    ang = m_angle + fl_div(rate + 50, 100);
    ang = lim(fl_div(98 * ang + 2 * acc + 50, 100), A180);
    m_angle = ang;
    err = longint'(regs.target_angle) - ang;
    integ = m_integ;
    if (err >= -DEADBAND_Q && err <= DEADBAND_Q) begin
      err = 0;
      integ = fl_div(integ * 199 + 100, 200);
    end
    err = lim(err, ERR_MAX_Q);
    integ = lim(integ + fl_div(err * 128 + 25, 50), INT_MAX_Q);
    m_integ = integ;
    deriv = (err - m_prev) * 100;
    m_prev = err;
    u = longint'(regs.prop_gain) * err * 256 + longint'(regs.integ_gain) * integ
        + longint'(regs.deriv_gain) * deriv * 256;
    u = lim(-(u * 30), DRV_MAX);
    mag = u < 0 ? -u : u;
    if (mag > 0 && mag < KICK_MIN) mag = KICK_MIN;
    r.duty = 10'(mag >>> 32);
    r.dir = u >= 0;
    r.angle = 25'(ang);
    return r;
  endfunction

  always @(posedge clk) begin
    drive_t got, want;
    if (!rst_n) begin
      regs <= '{PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, '0, '0, '0, '0};
      m_angle = 0; m_integ = 0; m_prev = 0; m_seed = 1;
      drive_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      // register write mirror
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          R_PROP:   regs.prop_gain    <= pwdata[15:0];
          R_INTEG:  regs.integ_gain   <= pwdata[15:0];
          R_DERIV:  regs.deriv_gain   <= pwdata[15:0];
          R_TARGET: regs.target_angle <= pwdata[24:0];
          R_AXB:    regs.accel_x_bias <= pwdata[15:0];
          R_AZB:    regs.accel_z_bias <= pwdata[15:0];
          R_GYB:    regs.gyro_bias    <= pwdata[25:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        drive_q.push_back(predict_drive(in_accel_x_sample, in_accel_z_sample,
                                        in_gyro_x_sample));
      if (out_valid && out_ready) begin
        got = '{out_pwm_duty, out_motor_direction, out_filtered_angle};
        if (drive_q.size() == 0) begin
          $display("%0t: result with no request outstanding: %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = drive_q.pop_front();
          if (got !== want) begin
            $display({"%0t: mismatch expected duty=%0d dir=%0d angle=%0d",
                      " actual duty=%0d dir=%0d angle=%0d"},
                     $time, want.duty, want.dir, want.angle,
                     got.duty, got.dir, got.angle);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= drive_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tbp_pkg::*;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  logic signed [15:0] ax = 0, az = 0, gx = 0;
  logic in_ready, out_valid, out_motor_direction, pready;
  logic [9:0] out_pwm_duty;
  logic signed [24:0] out_filtered_angle;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  int fail_count, pending;
  int send_idle = 0, recv_idle = 0;
  bit hold_off = 0, stim_done = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  tilt_balance_pid_controller DUT (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_accel_x_sample(ax), .in_accel_z_sample(az), .in_gyro_x_sample(gx),
    .out_valid, .out_ready, .out_pwm_duty, .out_motor_direction, .out_filtered_angle,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

  tb_tilt_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_accel_x_sample(ax), .in_accel_z_sample(az), .in_gyro_x_sample(gx),
    .out_valid, .out_ready, .out_pwm_duty, .out_motor_direction, .out_filtered_angle,
    .psel, .penable, .pwrite, .paddr, .pwdata, .fail_count, .pending);

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // valid stays up between back-to-back requests; it drops only on an idle cycle or in quiesce
  task automatic send_request(logic signed [15:0] x, logic signed [15:0] z,
                              logic signed [15:0] g);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; ax <= x; az <= z; gx <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drain outstanding results, then let the block settle before a write
  task automatic quiesce();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // random tilt near a plausible operating point, with occasional noise
  task automatic random_request();
    if ($urandom_range(9) < 8)
      send_request(16'($urandom_range(0, 8000)) - 16'sd4000,
                   16'sd16000 + 16'($urandom_range(0, 4000)),
                   16'($urandom_range(0, 4000)) - 16'sd2000);
    else
      send_request(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    #200000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    repeat (2) @(posedge clk);

    // directed: extremes and special cases
    send_request(0, 0, 0);                    // zero accel vector
    send_request(0, -16'sd32768, 0);          // Z negative, X zero
    send_request(16'sd32767, 16'sd32767, 16'sd32767);
    send_request(-16'sd32768, -16'sd32768, -16'sd32768);
    send_request(-16'sd32768, 16'sd64, 16'sd32767);
    send_request(16'sd32767, -16'sd64, -16'sd32768);
    repeat (8) send_request(16'sd64, 16'sd16384, 16'sd32767);  // drive angle to limit
    send_request(0, 16'sd16384, 0);
    send_request(16'sd63, 16'sd16384, 16'sd1);                 // accel X shifts down to zero
    quiesce();

    // register extremes
    reg_write(R_PROP, 32'hFFFF); reg_write(R_INTEG, 32'hFFFF); reg_write(R_DERIV, 32'hFFFF);
    reg_write(R_TARGET, 32'(11796480)); reg_write(R_AXB, 32'h7FFF);
    reg_write(R_AZB, 32'hFFFF8000); reg_write(R_GYB, 32'(18743296));
    repeat (6) random_request();
    quiesce();
    reg_write(R_PROP, 0); reg_write(R_INTEG, 0); reg_write(R_DERIV, 0);
    reg_write(R_TARGET, 32'(-11796480)); reg_write(R_AXB, 32'hFFFF8000);
    reg_write(R_AZB, 32'h7FFF); reg_write(R_GYB, 32'(-18743296));
    repeat (4) random_request();
    quiesce();
    reg_write(R_PROP, 4608); reg_write(R_INTEG, 154); reg_write(R_DERIV, 307);
    reg_write(R_TARGET, 0); reg_write(R_AXB, 0); reg_write(R_AZB, 0); reg_write(R_GYB, 0);

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (1500) @(posedge clk);
        hold_off = 0;
      end
      repeat (6) random_request();
    join

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 36 : (ph == 1 ? 58 : 0);
      recv_idle = ph == 0 ? 58 : (ph == 1 ? 36 : 0);
      quiesce();
      reg_write(R_PROP, $urandom_range(0, 65535));
      reg_write(R_INTEG, $urandom_range(0, 65535));
      reg_write(R_DERIV, $urandom_range(0, 65535));
      reg_write(R_TARGET, 32'($urandom_range(0, 2 * 11796480)) - 32'(11796480));
      reg_write(R_AXB, 32'($urandom_range(0, 400)) - 32'd200);
      reg_write(R_AZB, 32'($urandom_range(0, 400)) - 32'd200);
      reg_write(R_GYB, 32'($urandom_range(0, 2 * 18743296)) - 32'(18743296));
      repeat (275) random_request();
    end

    quiesce();
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tbp_pkg.sv
sv/tbp_div25.sv
sv/tbp_ctrl.sv
sv/tbp_dpath.sv
sv/tilt_balance_pid_controller.sv
tb/tb_tilt_checker.sv
tb/tb.sv
